@@ sv/tsvf_pkg.sv @@
package tsvf_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int DIGIT_W       = 4;
  localparam int DIG_IDX_W     = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
  localparam int TAIL_MAX      = 4;
  localparam int TAIL_IDX_W    = 2;
  localparam int TAIL_CNT_W    = 3;
  localparam int STEP_W        = $clog2(NUMBER_DIGITS + 1 + TAIL_MAX);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_IDX_W   = 2;
  localparam int QUEUE_CNT_W   = 3;

  localparam int MODE_W     = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_VIEW_MODE = 3'd0;

  localparam logic [MODE_W-1:0] MODE_PLAIN      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SQUEEZE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_NUMBER_ALL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_NUMBER_NB  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ENDS       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TABS       = 3'd5;
  localparam logic [MODE_W-1:0] MODE_ENDS_NP    = 3'd6;
  localparam logic [MODE_W-1:0] MODE_TABS_NP    = 3'd7;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_I      = 8'h49;

  typedef logic [NUMBER_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       new_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [TAIL_MAX-1:0][7:0] bytes;
    logic [TAIL_CNT_W-1:0]    cnt;
  } tail_t;

  typedef struct packed {
    logic  label;
    bcd_t  digits;
    tail_t tail;
  } job_t;

endpackage

@@ sv/tsvf_front.sv @@
module tsvf_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  tsvf_pkg::in_item_t           in_item,
  input  logic [tsvf_pkg::MODE_W-1:0]  view_mode,
  input  logic                         q_full,
  output logic                         q_push,
  output tsvf_pkg::job_t               q_job
);

  tsvf_pkg::bcd_t line_count_r, line_count_nxt;
  logic           at_line_start_r, at_line_start_nxt;
  logic [1:0]     newline_run_r, newline_run_nxt;

  tsvf_pkg::bcd_t lc;
  logic           als;
  logic [1:0]     run;
  logic           accept;
  logic           nl;
  logic           tab;
  logic           adv;
  logic [7:0]     c;
  tsvf_pkg::job_t job;

  function automatic tsvf_pkg::bcd_t bcd_one();
    tsvf_pkg::bcd_t v;
    v = '0;
    v[0] = tsvf_pkg::DIGIT_W'(1);
    return v;
  endfunction

  function automatic tsvf_pkg::bcd_t bcd_advance(tsvf_pkg::bcd_t v);
    tsvf_pkg::bcd_t r;
    logic           all_nine;
    logic           carry;
    r = v;
    all_nine = 1'b1;
    carry = 1'b1;
    for (int i = 0; i < tsvf_pkg::NUMBER_DIGITS; i++) begin
      if (v[i] != tsvf_pkg::DIGIT_W'(9)) begin
        all_nine = 1'b0;
      end
    end
    if (!all_nine) begin
      for (int i = 0; i < tsvf_pkg::NUMBER_DIGITS; i++) begin
        if (carry) begin
          if (v[i] == tsvf_pkg::DIGIT_W'(9)) begin
            r[i] = '0;
          end else begin
            r[i] = v[i] + tsvf_pkg::DIGIT_W'(1);
            carry = 1'b0;
          end
        end
      end
    end
    return r;
  endfunction

  function automatic tsvf_pkg::tail_t single(logic [7:0] b);
    tsvf_pkg::tail_t t;
    t = '0;
    t.bytes[0] = b;
    t.cnt = tsvf_pkg::TAIL_CNT_W'(1);
    return t;
  endfunction

  function automatic tsvf_pkg::tail_t pair(logic [7:0] b0, logic [7:0] b1);
    tsvf_pkg::tail_t t;
    t = '0;
    t.bytes[0] = b0;
    t.bytes[1] = b1;
    t.cnt = tsvf_pkg::TAIL_CNT_W'(2);
    return t;
  endfunction

  function automatic tsvf_pkg::tail_t nonprint(logic [7:0] b);
    tsvf_pkg::tail_t t;
    t = '0;
    priority if (b >= 8'd32 && b <= 8'd126) begin
      t.bytes[0] = b;
      t.cnt = tsvf_pkg::TAIL_CNT_W'(1);
    end else if (b == 8'd127) begin
      t.bytes[0] = tsvf_pkg::CH_CARET;
      t.bytes[1] = tsvf_pkg::CH_QMARK;
      t.cnt = tsvf_pkg::TAIL_CNT_W'(2);
    end else if (b < 8'd32) begin
      t.bytes[0] = tsvf_pkg::CH_CARET;
      t.bytes[1] = b + 8'd64;
      t.cnt = tsvf_pkg::TAIL_CNT_W'(2);
    end else if (b <= 8'd159) begin
      t.bytes[0] = tsvf_pkg::CH_M;
      t.bytes[1] = tsvf_pkg::CH_DASH;
      t.bytes[2] = tsvf_pkg::CH_CARET;
      t.bytes[3] = b - 8'd64;
      t.cnt = tsvf_pkg::TAIL_CNT_W'(4);
    end else if (b <= 8'd254) begin
      t.bytes[0] = tsvf_pkg::CH_M;
      t.bytes[1] = tsvf_pkg::CH_DASH;
      t.bytes[2] = b - 8'd128;
      t.cnt = tsvf_pkg::TAIL_CNT_W'(3);
    end else begin
      t.bytes[0] = tsvf_pkg::CH_M;
      t.bytes[1] = tsvf_pkg::CH_DASH;
      t.bytes[2] = tsvf_pkg::CH_CARET;
      t.bytes[3] = tsvf_pkg::CH_QMARK;
      t.cnt = tsvf_pkg::TAIL_CNT_W'(4);
    end
    return t;
  endfunction

  assign full   = q_full;
  assign accept = push && !q_full;
  assign c      = in_item.in_byte;
  assign nl     = (c == tsvf_pkg::CH_NL);
  assign tab    = (c == tsvf_pkg::CH_TAB);

  always_comb begin
    lc  = in_item.new_file ? bcd_one() : line_count_r;
    als = in_item.new_file ? 1'b1 : at_line_start_r;
    run = in_item.new_file ? 2'd1 : newline_run_r;

    job        = '0;
    job.digits = lc;
    job.tail   = single(c);
    adv        = 1'b0;

    unique case (view_mode)
      tsvf_pkg::MODE_PLAIN: begin
      end
      tsvf_pkg::MODE_SQUEEZE: begin
        if (nl && run == 2'd2) begin
          job.tail = '0;
        end
      end
      tsvf_pkg::MODE_NUMBER_ALL: begin
        job.label = als;
        adv = nl;
      end
      tsvf_pkg::MODE_NUMBER_NB: begin
        job.label = als && !nl;
        adv = als && !nl;
      end
      tsvf_pkg::MODE_ENDS: begin
        if (nl) begin
          job.tail = pair(tsvf_pkg::CH_DOLLAR, c);
        end
      end
      tsvf_pkg::MODE_TABS: begin
        if (tab) begin
          job.tail = pair(tsvf_pkg::CH_CARET, tsvf_pkg::CH_I);
        end
      end
      tsvf_pkg::MODE_ENDS_NP: begin
        if (nl) begin
          job.tail = pair(tsvf_pkg::CH_DOLLAR, c);
        end else if (!tab) begin
          job.tail = nonprint(c);
        end
      end
      tsvf_pkg::MODE_TABS_NP: begin
        if (tab) begin
          job.tail = pair(tsvf_pkg::CH_CARET, tsvf_pkg::CH_I);
        end else if (!nl) begin
          job.tail = nonprint(c);
        end
      end
      default: begin
      end
    endcase

    line_count_nxt    = adv ? bcd_advance(lc) : lc;
    at_line_start_nxt = nl;
    if (nl) begin
      newline_run_nxt = (run < 2'd2) ? run + 2'd1 : run;
    end else begin
      newline_run_nxt = 2'd0;
    end
  end

  assign q_push = accept && (job.tail.cnt != '0);
  assign q_job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r    <= bcd_one();
      at_line_start_r <= 1'b1;
      newline_run_r   <= 2'd1;
    end else if (accept) begin
      line_count_r    <= line_count_nxt;
      at_line_start_r <= at_line_start_nxt;
      newline_run_r   <= newline_run_nxt;
    end
  end

endmodule

@@ sv/tsvf_job_queue.sv @@
module tsvf_job_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_push,
  input  tsvf_pkg::job_t q_wdata,
  output logic           q_full,
  input  logic           q_pop,
  output tsvf_pkg::job_t q_rdata,
  output logic           q_empty
);

  tsvf_pkg::job_t                       mem [tsvf_pkg::QUEUE_DEPTH];
  logic [tsvf_pkg::QUEUE_IDX_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [tsvf_pkg::QUEUE_IDX_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [tsvf_pkg::QUEUE_CNT_W-1:0]     count_r, count_nxt;
  logic                                 do_push;
  logic                                 do_pop;

  assign q_full  = (count_r == tsvf_pkg::QUEUE_CNT_W'(tsvf_pkg::QUEUE_DEPTH));
  assign q_empty = (count_r == '0);
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_rdata = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + tsvf_pkg::QUEUE_IDX_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + tsvf_pkg::QUEUE_IDX_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + tsvf_pkg::QUEUE_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - tsvf_pkg::QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ sv/tsvf_back.sv @@
module tsvf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tsvf_pkg::job_t      q_job,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output tsvf_pkg::out_item_t out_item
);

  localparam int ND = tsvf_pkg::NUMBER_DIGITS;
  localparam int SW = tsvf_pkg::STEP_W;

  logic [SW-1:0]                    step_r, step_nxt;
  logic                             lead_r, lead_nxt;
  logic                             out_valid_r, out_valid_nxt;
  tsvf_pkg::out_item_t              out_r, out_nxt;

  logic                             advance;
  logic [SW-1:0]                    total;
  logic [SW-1:0]                    tail_step;
  logic [tsvf_pkg::TAIL_IDX_W-1:0]  tail_idx;
  logic [tsvf_pkg::DIG_IDX_W-1:0]   dig_idx;
  logic [tsvf_pkg::DIGIT_W-1:0]     digit;
  logic                             in_digits;
  logic                             at_tab;
  logic                             blank;
  logic                             is_last;
  logic [7:0]                       byte_val;

  assign advance = !q_empty && (!out_valid_r || pop);

  always_comb begin
    total     = q_job.label ? SW'(ND + 1) + SW'(q_job.tail.cnt) : SW'(q_job.tail.cnt);
    in_digits = q_job.label && (step_r < SW'(ND));
    at_tab    = q_job.label && (step_r == SW'(ND));
    tail_step = q_job.label ? step_r - SW'(ND + 1) : step_r;
    tail_idx  = tail_step[tsvf_pkg::TAIL_IDX_W-1:0];
    dig_idx   = tsvf_pkg::DIG_IDX_W'(SW'(ND - 1) - step_r);
    digit     = q_job.digits[dig_idx];
    blank     = lead_r && (digit == '0) && (dig_idx != '0);
    is_last   = (step_r == total - SW'(1));

    priority if (in_digits) begin
      byte_val = blank ? tsvf_pkg::CH_SPACE : tsvf_pkg::CH_ZERO + 8'(digit);
    end else if (at_tab) begin
      byte_val = tsvf_pkg::CH_TAB;
    end else begin
      byte_val = q_job.tail.bytes[tail_idx];
    end

    step_nxt      = step_r;
    lead_nxt      = lead_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_nxt.out_byte = byte_val;
      out_nxt.last     = is_last;
      out_valid_nxt    = 1'b1;
      if (is_last) begin
        step_nxt = '0;
        lead_nxt = 1'b1;
      end else begin
        step_nxt = step_r + SW'(1);
        if (in_digits) begin
          lead_nxt = blank;
        end
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign q_pop    = advance && is_last;
  assign empty    = !out_valid_r;
  assign out_item = out_r;

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      lead_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      lead_r      <= lead_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/text_stream_view_filter_core.sv @@
// Shows a byte stream in display form, one input byte becoming zero to eight result bytes
// under the view chosen by the view_mode register at address 0. The front end takes one
// input byte per cycle while the job queue is not full, tracks the line state and places a
// description of the display form in a four-entry job queue; the back end spells each job out
// at one result byte per cycle, while results are taken, into a single output register. The
// back end sets the sustained rate; a numbered line start yields eight result bytes. An input
// byte's first result passes through the job queue and then the output register. Bytes that
// yield nothing never occupy the queue. Change view_mode only while the block is idle.
module text_stream_view_filter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  tsvf_pkg::in_item_t                in_item,
  output logic                              empty,
  input  logic                              pop,
  output tsvf_pkg::out_item_t               out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tsvf_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tsvf_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tsvf_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic [tsvf_pkg::MODE_W-1:0] view_mode_r, view_mode_nxt;
  logic                        cfg_write;
  logic                        q_push;
  logic                        q_full;
  logic                        q_pop;
  logic                        q_empty;
  tsvf_pkg::job_t              q_wdata;
  tsvf_pkg::job_t              q_rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == tsvf_pkg::CFG_ADDR_VIEW_MODE);
  assign view_mode_nxt = cfg_write ? pwdata[tsvf_pkg::MODE_W-1:0] : view_mode_r;
  assign prdata = (paddr == tsvf_pkg::CFG_ADDR_VIEW_MODE) ?
                  tsvf_pkg::CFG_DATA_W'(view_mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_mode_r <= tsvf_pkg::MODE_PLAIN;
    end else begin
      view_mode_r <= view_mode_nxt;
    end
  end

  tsvf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .view_mode (view_mode_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_wdata)
  );

  tsvf_job_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty)
  );

  tsvf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_job    (q_rdata),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule

@@ sv/tsvf_checker.sv @@
module tsvf_prop_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input tsvf_pkg::out_item_t               out_item,
  input logic [tsvf_pkg::CFG_DATA_W-1:0]   prdata,
  input logic                              pready
);

  a_pready_high: assert property (@(posedge clk) pready)
    else $error("pready dropped");

  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> empty)
    else $error("result present straight after reset");

  a_reset_not_full: assert property (@(posedge clk) $past(!rst_n) |-> !full)
    else $error("input side full straight after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed before its transfer");

  a_prdata_narrow: assert property (@(posedge clk)
    prdata[tsvf_pkg::CFG_DATA_W-1:tsvf_pkg::MODE_W] == '0)
    else $error("read data wider than the view mode register");

endmodule

bind text_stream_view_filter_core tsvf_prop_checker u_tsvf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item),
  .prdata   (prdata),
  .pready   (pready)
);

@@ sim/tsvf_checker.sv @@
`timescale 1ns / 1ps
module tsvf_checker
  import tsvf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic                  full,
  input  in_item_t              in_item,
  input  logic                  empty,
  input  logic                  pop,
  input  out_item_t             out_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    pending
);

  bcd_t              line_no;
  logic              line_fresh;
  logic [1:0]        blank_run;
  logic [MODE_W-1:0] view;
  logic [7:0]        spell_q[$];
  out_item_t         shown_q[$];
  out_item_t         want;

  task automatic restart_file();
    line_no    = '0;
    line_no[0] = 4'd1;
    line_fresh = 1'b1;
    blank_run  = 2'd1;
  endtask

  function automatic bcd_t count_next(input bcd_t n);
    bcd_t r;
    bit   top;
    r   = n;
    top = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (n[i] != 4'd9) top = 1'b0;
    end
    if (top) return n;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (r[i] < 4'd9) begin
        r[i] = r[i] + 4'd1;
        return r;
      end
      r[i] = 4'd0;
    end
    return r;
  endfunction

  task automatic add_label();
    bit lead;
    lead = 1'b1;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      if (line_no[i] != 4'd0 || i == 0) lead = 1'b0;
      spell_q.push_back(lead ? CH_SPACE : CH_ZERO + 8'(line_no[i]));
    end
    spell_q.push_back(CH_TAB);
  endtask

  task automatic add_nonprint(input logic [7:0] c);
    if (c >= 8'd32 && c <= 8'd126) begin
      spell_q.push_back(c);
    end else if (c == 8'd127) begin
      spell_q.push_back(CH_CARET);
      spell_q.push_back(CH_QMARK);
    end else if (c < 8'd32) begin
      spell_q.push_back(CH_CARET);
      spell_q.push_back(c + 8'd64);
    end else if (c <= 8'd159) begin
      spell_q.push_back(CH_M);
      spell_q.push_back(CH_DASH);
      spell_q.push_back(CH_CARET);
      spell_q.push_back(c - 8'd64);
    end else if (c <= 8'd254) begin
      spell_q.push_back(CH_M);
      spell_q.push_back(CH_DASH);
      spell_q.push_back(c - 8'd128);
    end else begin
      spell_q.push_back(CH_M);
      spell_q.push_back(CH_DASH);
      spell_q.push_back(CH_CARET);
      spell_q.push_back(CH_QMARK);
    end
  endtask

  task automatic render(input in_item_t it);
    logic [7:0] c;
    logic       nl;
    out_item_t  r;
    c = it.in_byte;
    nl = (c == CH_NL);
    spell_q.delete();
    if (it.new_file) restart_file();
    case (view)
      MODE_SQUEEZE: begin
        if (!(nl && blank_run >= 2'd2)) spell_q.push_back(c);
      end
      MODE_NUMBER_ALL: begin
        if (line_fresh) add_label();
        spell_q.push_back(c);
        if (nl) line_no = count_next(line_no);
      end
      MODE_NUMBER_NB: begin
        if (line_fresh && !nl) begin
          add_label();
          line_no = count_next(line_no);
        end
        spell_q.push_back(c);
      end
      MODE_ENDS: begin
        if (nl) spell_q.push_back(CH_DOLLAR);
        spell_q.push_back(c);
      end
      MODE_TABS: begin
        if (c == CH_TAB) begin
          spell_q.push_back(CH_CARET);
          spell_q.push_back(CH_I);
        end else begin
          spell_q.push_back(c);
        end
      end
      MODE_ENDS_NP: begin
        if (nl) begin
          spell_q.push_back(CH_DOLLAR);
          spell_q.push_back(c);
        end else if (c == CH_TAB) begin
          spell_q.push_back(c);
        end else begin
          add_nonprint(c);
        end
      end
      MODE_TABS_NP: begin
        if (c == CH_TAB) begin
          spell_q.push_back(CH_CARET);
          spell_q.push_back(CH_I);
        end else if (nl) begin
          spell_q.push_back(c);
        end else begin
          add_nonprint(c);
        end
      end
      default: spell_q.push_back(c);
    endcase
    if (nl) begin
      if (blank_run < 2'd2) blank_run = blank_run + 2'd1;
    end else begin
      blank_run = 2'd0;
    end
    line_fresh = nl;
    foreach (spell_q[i]) begin
      r.out_byte = spell_q[i];
      r.last     = (i == spell_q.size() - 1);
      shown_q.push_back(r);
    end
  endtask

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_file();
      view = MODE_PLAIN;
      shown_q.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      // A result transfer at this edge can only belong to an input taken at an earlier one.
      if (pop && !empty) begin
        if (shown_q.size() == 0) begin
          note_fail($sformatf("unexpected result: byte %02h last %0b",
                              out_item.out_byte, out_item.last));
        end else begin
          want = shown_q.pop_front();
          if (want.out_byte !== out_item.out_byte || want.last !== out_item.last) begin
            note_fail($sformatf("result mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                want.out_byte, want.last, out_item.out_byte, out_item.last));
          end
        end
      end
      if (push && !full) render(in_item);
      if (psel && penable && pwrite && pready && paddr == CFG_ADDR_VIEW_MODE) begin
        view = pwdata[MODE_W-1:0];
      end
      pending <= shown_q.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import tsvf_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic                  clk;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  in_item_t              in_item;
  logic                  empty;
  logic                  pop;
  out_item_t             out_item;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;
  int                    cycles = 0;
  int                    stall_left = 0;
  logic                  idle_on;

  logic [MODE_W-1:0] phase_modes[10] = '{MODE_TABS_NP, MODE_PLAIN, MODE_NUMBER_ALL, MODE_ENDS,
                                         MODE_TABS, MODE_SQUEEZE, MODE_ENDS_NP, MODE_NUMBER_NB,
                                         MODE_TABS_NP, MODE_PLAIN};
  logic [7:0] np_probe[13] = '{8'h00, 8'h1F, 8'h20, 8'h7E, 8'h7F, 8'h80, 8'h9F, 8'hA0,
                               8'hFE, 8'hFF, CH_TAB, CH_NL, 8'h41};

  text_stream_view_filter_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tsvf_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The result side stalls in random bursts while idling is enabled.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      pop        <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return CH_NL;
    if (r < 30) return CH_TAB;
    if (r < 75) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input logic [7:0] b, input logic nf);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= '{in_byte: b, new_file: nf};
    do @(posedge clk); while (full);
  endtask

  task automatic drain();
    push <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_view(input logic [MODE_W-1:0] m);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_VIEW_MODE;
    pwdata  <= CFG_DATA_W'(m);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    rst_n   <= 1'b0;
    push    <= 1'b0;
    in_item <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    idle_on <= 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_view(MODE_ENDS_NP);
    foreach (np_probe[i]) send_item(np_probe[i], 1'b0);
    drain();
    write_view(MODE_SQUEEZE);
    send_item(CH_NL, 1'b1);
    send_item(CH_NL, 1'b0);
    send_item(CH_NL, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(CH_NL, 1'b0);
    drain();
    write_view(MODE_NUMBER_NB);
    send_item(8'h61, 1'b1);
    send_item(CH_NL, 1'b0);
    send_item(CH_NL, 1'b0);
    send_item(8'h62, 1'b0);

    foreach (phase_modes[p]) begin
      drain();
      idle_on <= ($urandom_range(0, 3) != 0);
      write_view(phase_modes[p]);
      repeat ($urandom_range(18, 30)) send_item(text_byte(), $urandom_range(0, 29) == 0);
    end

    // A long numbered file carries the line label past two decimal digits.
    drain();
    idle_on <= 1'b1;
    write_view(MODE_NUMBER_ALL);
    for (int i = 0; i < 120; i++) send_item((i % 8 == 7) ? text_byte() : CH_NL, i == 0);

    drain();
    idle_on <= 1'b0;
    write_view(MODE_TABS_NP);
    repeat (40) send_item(text_byte(), $urandom_range(0, 29) == 0);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
